// ----- hw/rtl/obb_pair_sat_penetration_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef OBB_PAIR_SAT_PENETRATION_DEFINES_SVH
`define OBB_PAIR_SAT_PENETRATION_DEFINES_SVH

// clocked property, ignored while reset is high
`define OBB_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("obb_pair_sat_penetration: assertion failed");

// clocked property, checked during reset as well
`define OBB_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("obb_pair_sat_penetration: assertion failed");

`endif

// ----- hw/rtl/obbsat_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obbsat_pkg
// Constants and types of the oriented-box separating-axis block.
// ---------------------------------------------------------------------------
package obbsat_pkg;

   localparam int REQ_W = 288;
   localparam int RSP_W = 72;

   // result field offsets in rsp_tdata
   localparam int HIT_LSB   = 0;
   localparam int NX_LSB    = 1;
   localparam int NY_LSB    = 17;
   localparam int DEPTH_LSB = 33;

   localparam logic [30:0] SIN_A = 31'd1686629713;
   localparam logic [29:0] SIN_B = 30'd688904866;
   localparam logic [26:0] SIN_C = 27'd76016977;

   localparam logic [15:0] ANG_QUARTER = 16'd16384;
   localparam logic [31:0] DEPTH_MAX   = 32'hFFFF_FFFF;
   localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

   localparam int CW = 35;   // corner coordinate width
   localparam int DW = 52;   // projection width

   typedef logic signed [15:0]   trig_type;
   typedef logic signed [CW-1:0] corner_type;
   typedef logic signed [DW-1:0] dot_type;

   typedef struct packed {
      logic     have;
      dot_type  ov;
      trig_type nx;
      trig_type ny;
   } sel_type;

endpackage

// ----- hw/rtl/obb_pair_sat_penetration.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obb_pair_sat_penetration
// Separating-axis overlap test of two rotated rectangles with push normal
// and penetration depth.
// ---------------------------------------------------------------------------
//  channel  direction  width  contents
//  req_*    in         288    box A and box B (center, angle, width, height)
//  rsp_*    out        72     hit, normal_x, normal_y, depth
//
//  Fourteen register stages; one request per cycle while the output is not stalled.
//  The sine evaluation (four chained multiplies) and the 32 corner
//  projections set the depth of the pipe.
//  Reset clears the stage valid bits only.
//  Each stage holds while the next one is full and stalled; bubbles close up.
// ---------------------------------------------------------------------------
module obb_pair_sat_penetration
   import obbsat_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // a_center_x, a_center_y, a_angle, a_width, a_height,
   // b_center_x, b_center_y, b_angle, b_width, b_height
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // hit, normal_x, normal_y, depth, zero fill
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int NST = 14;

   logic [NST:1] v_ff;
   logic [NST+1:1] en;

   always_comb begin
      en[NST+1] = rsp_tready;
      for (int k = NST; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = v_ff[NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ---------------- input unpack ----------------
   logic signed [31:0] cx_in [2];
   logic signed [31:0] cy_in [2];
   logic [15:0]        ang_in [2];
   logic [31:0]        w_in [2];
   logic [31:0]        h_in [2];

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         cx_in[b]  = req_tdata[b*144 +: 32];
         cy_in[b]  = req_tdata[b*144 + 32 +: 32];
         ang_in[b] = req_tdata[b*144 + 64 +: 16];
         w_in[b]   = req_tdata[b*144 + 80 +: 32];
         h_in[b]   = req_tdata[b*144 + 112 +: 32];
      end
   end

   // ---------------- stage 1: fold angles, square ----------------
   // trig index: 0 sin A, 1 cos A, 2 sin B, 3 cos B
   logic [14:0] m_in [4];
   logic        neg_in [4];
   logic [15:0] t_ang [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         t_ang[i] = ang_in[i/2] + ((i % 2 == 1) ? ANG_QUARTER : 16'd0);
         if (t_ang[i] <= 16'd16384) begin
            m_in[i] = t_ang[i][14:0]; neg_in[i] = 1'b0;
         end else if (t_ang[i] <= 16'd32768) begin
            m_in[i] = 15'(17'd32768 - {1'b0, t_ang[i]}); neg_in[i] = 1'b0;
         end else if (t_ang[i] <= 16'd49152) begin
            m_in[i] = 15'(t_ang[i] - 16'd32768); neg_in[i] = 1'b1;
         end else begin
            m_in[i] = 15'(17'd65536 - {1'b0, t_ang[i]}); neg_in[i] = 1'b1;
         end
      end
   end

   logic [14:0] m1_ff [4];
   logic        neg1_ff [4];
   logic [28:0] x2_1_ff [4];
   logic signed [31:0] cx1_ff [2], cy1_ff [2];
   logic [31:0] w1_ff [2], h1_ff [2];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 4; i++) begin
            m1_ff[i]   <= m_in[i];
            neg1_ff[i] <= neg_in[i];
            x2_1_ff[i] <= 29'(m_in[i] * m_in[i]);
         end
         for (int b = 0; b < 2; b++) begin
            cx1_ff[b] <= cx_in[b]; cy1_ff[b] <= cy_in[b];
            w1_ff[b]  <= w_in[b];  h1_ff[b]  <= h_in[b];
         end
      end
   end

   // ---------------- stage 2: inner term ----------------
   logic [55:0] pc_in [4];
   logic [14:0] m2_ff [4];
   logic        neg2_ff [4];
   logic [28:0] x2_2_ff [4];
   logic [29:0] inner2_ff [4];
   logic signed [31:0] cx2_ff [2], cy2_ff [2];
   logic [31:0] w2_ff [2], h2_ff [2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pc_in[i] = 56'(SIN_C) * 56'(x2_1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 4; i++) begin
            m2_ff[i]     <= m1_ff[i];
            neg2_ff[i]   <= neg1_ff[i];
            x2_2_ff[i]   <= x2_1_ff[i];
            inner2_ff[i] <= SIN_B - 30'(pc_in[i][55:28]);
         end
         cx2_ff <= cx1_ff; cy2_ff <= cy1_ff; w2_ff <= w1_ff; h2_ff <= h1_ff;
      end
   end

   // ---------------- stage 3: polynomial ----------------
   logic [58:0] pi_in [4];
   logic [14:0] m3_ff [4];
   logic        neg3_ff [4];
   logic [30:0] p3_ff [4];
   logic signed [31:0] cx3_ff [2], cy3_ff [2];
   logic [31:0] w3_ff [2], h3_ff [2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pi_in[i] = 59'(inner2_ff[i]) * 59'(x2_2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < 4; i++) begin
            m3_ff[i]   <= m2_ff[i];
            neg3_ff[i] <= neg2_ff[i];
            p3_ff[i]   <= SIN_A - pi_in[i][58:28];
         end
         cx3_ff <= cx2_ff; cy3_ff <= cy2_ff; w3_ff <= w2_ff; h3_ff <= h2_ff;
      end
   end

   // ---------------- stage 4: sine and cosine ----------------
   logic [45:0] pm_in [4];
   logic [15:0] r_in [4];
   trig_type    trig4_ff [4];
   logic signed [31:0] cx4_ff [2], cy4_ff [2];
   logic [31:0] w4_ff [2], h4_ff [2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pm_in[i] = 46'(m3_ff[i]) * 46'(p3_ff[i]) + 46'(64'd1 << 29);
         r_in[i]  = pm_in[i][45:30];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int i = 0; i < 4; i++) begin
            trig4_ff[i] <= neg3_ff[i] ? -$signed(r_in[i]) : $signed(r_in[i]);
         end
         cx4_ff <= cx3_ff; cy4_ff <= cy3_ff; w4_ff <= w3_ff; h4_ff <= h3_ff;
      end
   end

   // ---------------- stage 5: size times trig ----------------
   logic signed [48:0] wc5_ff [2], hs5_ff [2], hc5_ff [2], ws5_ff [2];
   trig_type    trig5_ff [4];
   logic signed [31:0] cx5_ff [2], cy5_ff [2];
   logic        okw5_ff [2], okh5_ff [2];

   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int b = 0; b < 2; b++) begin
            wc5_ff[b] <= $signed({1'b0, w4_ff[b]}) * trig4_ff[2*b+1];
            hs5_ff[b] <= $signed({1'b0, h4_ff[b]}) * trig4_ff[2*b];
            hc5_ff[b] <= $signed({1'b0, h4_ff[b]}) * trig4_ff[2*b+1];
            ws5_ff[b] <= $signed({1'b0, w4_ff[b]}) * trig4_ff[2*b];
            okw5_ff[b] <= (w4_ff[b] != 32'd0);
            okh5_ff[b] <= (h4_ff[b] != 32'd0);
         end
         trig5_ff <= trig4_ff; cx5_ff <= cx4_ff; cy5_ff <= cy4_ff;
      end
   end

   // ---------------- stage 6: corners and axes ----------------
   localparam logic signed [49:0] RND15 = 50'sd16384;
   logic signed [49:0] ex_t [2], ey_t [2], gx_t [2], gy_t [2];
   corner_type ex_in [2], ey_in [2], gx_in [2], gy_in [2];
   corner_type cxe [2], cye [2];

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         ex_t[b] = 50'(wc5_ff[b]) + 50'(hs5_ff[b]) + RND15;
         ey_t[b] = 50'(hc5_ff[b]) - 50'(ws5_ff[b]) + RND15;
         gx_t[b] = 50'(wc5_ff[b]) - 50'(hs5_ff[b]) + RND15;
         gy_t[b] = -50'(ws5_ff[b]) - 50'(hc5_ff[b]) + RND15;
         // floor of (v + half) / 2^15
         ex_in[b] = ex_t[b][49:15];
         ey_in[b] = ey_t[b][49:15];
         gx_in[b] = gx_t[b][49:15];
         gy_in[b] = gy_t[b][49:15];
         cxe[b] = CW'(cx5_ff[b]);
         cye[b] = CW'(cy5_ff[b]);
      end
   end

   corner_type px6_ff [2][4], py6_ff [2][4];
   trig_type   ux6_ff [4], uy6_ff [4];
   logic       ok6_ff [4];
   logic signed [32:0] dx6_ff, dy6_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int b = 0; b < 2; b++) begin
            px6_ff[b][0] <= cxe[b] - ex_in[b]; py6_ff[b][0] <= cye[b] - ey_in[b];
            px6_ff[b][1] <= cxe[b] + gx_in[b]; py6_ff[b][1] <= cye[b] + gy_in[b];
            px6_ff[b][2] <= cxe[b] + ex_in[b]; py6_ff[b][2] <= cye[b] + ey_in[b];
            px6_ff[b][3] <= cxe[b] - gx_in[b]; py6_ff[b][3] <= cye[b] - gy_in[b];
            ux6_ff[2*b]   <= trig5_ff[2*b];
            uy6_ff[2*b]   <= trig5_ff[2*b+1];
            ux6_ff[2*b+1] <= -trig5_ff[2*b+1];
            uy6_ff[2*b+1] <= trig5_ff[2*b];
            ok6_ff[2*b]   <= okw5_ff[b];
            ok6_ff[2*b+1] <= okh5_ff[b];
         end
         dx6_ff <= 33'(cx5_ff[1]) - 33'(cx5_ff[0]);
         dy6_ff <= 33'(cy5_ff[1]) - 33'(cy5_ff[0]);
      end
   end

   // ---------------- stage 7: projection products ----------------
   logic signed [50:0] qx7_ff [4][2][4], qy7_ff [4][2][4];
   trig_type   ux7_ff [4], uy7_ff [4];
   logic       ok7_ff [4];
   logic signed [32:0] dx7_ff, dy7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int j = 0; j < 4; j++) begin
            for (int b = 0; b < 2; b++) begin
               for (int k = 0; k < 4; k++) begin
                  qx7_ff[j][b][k] <= px6_ff[b][k] * ux6_ff[j];
                  qy7_ff[j][b][k] <= py6_ff[b][k] * uy6_ff[j];
               end
            end
         end
         ux7_ff <= ux6_ff; uy7_ff <= uy6_ff; ok7_ff <= ok6_ff;
         dx7_ff <= dx6_ff; dy7_ff <= dy6_ff;
      end
   end

   // ---------------- stage 8: projection sums ----------------
   dot_type    d8_ff [4][2][4];
   trig_type   ux8_ff [4], uy8_ff [4];
   logic       ok8_ff [4];
   logic signed [32:0] dx8_ff, dy8_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         for (int j = 0; j < 4; j++) begin
            for (int b = 0; b < 2; b++) begin
               for (int k = 0; k < 4; k++) begin
                  d8_ff[j][b][k] <= DW'(qx7_ff[j][b][k]) + DW'(qy7_ff[j][b][k]);
               end
            end
         end
         ux8_ff <= ux7_ff; uy8_ff <= uy7_ff; ok8_ff <= ok7_ff;
         dx8_ff <= dx7_ff; dy8_ff <= dy7_ff;
      end
   end

   // ---------------- stage 9: extent per box and axis ----------------
   dot_type lo_in [4][2], hi_in [4][2];
   dot_type l01, l23, h01, h23;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int b = 0; b < 2; b++) begin
            l01 = (d8_ff[j][b][1] < d8_ff[j][b][0]) ? d8_ff[j][b][1] : d8_ff[j][b][0];
            l23 = (d8_ff[j][b][3] < d8_ff[j][b][2]) ? d8_ff[j][b][3] : d8_ff[j][b][2];
            h01 = (d8_ff[j][b][1] > d8_ff[j][b][0]) ? d8_ff[j][b][1] : d8_ff[j][b][0];
            h23 = (d8_ff[j][b][3] > d8_ff[j][b][2]) ? d8_ff[j][b][3] : d8_ff[j][b][2];
            lo_in[j][b] = (l23 < l01) ? l23 : l01;
            hi_in[j][b] = (h23 > h01) ? h23 : h01;
         end
      end
   end

   dot_type    lo9_ff [4][2], hi9_ff [4][2];
   trig_type   ux9_ff [4], uy9_ff [4];
   logic       ok9_ff [4];
   logic signed [32:0] dx9_ff, dy9_ff;

   always_ff @(posedge clock) begin
      if (en[9]) begin
         lo9_ff <= lo_in; hi9_ff <= hi_in;
         ux9_ff <= ux8_ff; uy9_ff <= uy8_ff; ok9_ff <= ok8_ff;
         dx9_ff <= dx8_ff; dy9_ff <= dy8_ff;
      end
   end

   // ---------------- stage 10: gap and overlap ----------------
   sel_type  cand_in [4];
   logic     sep_in;
   dot_type  hmin, lmax;

   always_comb begin
      sep_in = 1'b0;
      for (int j = 0; j < 4; j++) begin
         hmin = (hi9_ff[j][0] < hi9_ff[j][1]) ? hi9_ff[j][0] : hi9_ff[j][1];
         lmax = (lo9_ff[j][0] > lo9_ff[j][1]) ? lo9_ff[j][0] : lo9_ff[j][1];
         if (ok9_ff[j] &&
             (hi9_ff[j][0] < lo9_ff[j][1] || hi9_ff[j][1] < lo9_ff[j][0])) begin
            sep_in = 1'b1;
         end
         cand_in[j].have = ok9_ff[j];
         cand_in[j].ov   = hmin - lmax;
         cand_in[j].nx   = ux9_ff[j];
         cand_in[j].ny   = uy9_ff[j];
      end
   end

   sel_type cand10_ff [4];
   logic    sep10_ff;
   logic signed [32:0] dx10_ff, dy10_ff;

   always_ff @(posedge clock) begin
      if (en[10]) begin
         cand10_ff <= cand_in; sep10_ff <= sep_in;
         dx10_ff <= dx9_ff; dy10_ff <= dy9_ff;
      end
   end

   // ---------------- stages 11, 12: pick smallest overlap ----------------
   // the earlier axis keeps a tie
   function automatic sel_type pick(input sel_type l, input sel_type r);
      sel_type o;
      if (!l.have) o = r;
      else if (r.have && r.ov < l.ov) o = r;
      else o = l;
      return o;
   endfunction

   sel_type sel11_ff [2];
   logic    sep11_ff;
   logic signed [32:0] dx11_ff, dy11_ff;

   always_ff @(posedge clock) begin
      if (en[11]) begin
         sel11_ff[0] <= pick(cand10_ff[0], cand10_ff[1]);
         sel11_ff[1] <= pick(cand10_ff[2], cand10_ff[3]);
         sep11_ff <= sep10_ff; dx11_ff <= dx10_ff; dy11_ff <= dy10_ff;
      end
   end

   sel_type sel12_ff;
   logic    sep12_ff;
   logic signed [32:0] dx12_ff, dy12_ff;

   always_ff @(posedge clock) begin
      if (en[12]) begin
         sel12_ff <= pick(sel11_ff[0], sel11_ff[1]);
         sep12_ff <= sep11_ff; dx12_ff <= dx11_ff; dy12_ff <= dy11_ff;
      end
   end

   // ---------------- stage 13: direction products, depth rounding ----------------
   logic [DW:0]  dr_in;
   logic [31:0]  depth_in;

   always_comb begin
      if (!sel12_ff.have) begin
         dr_in    = '0;
         depth_in = DEPTH_MAX;
      end else begin
         dr_in    = (DW+1)'($unsigned(sel12_ff.ov)) + (DW+1)'(64'd1 << 13);
         depth_in = (|dr_in[DW:46]) ? DEPTH_MAX : dr_in[45:14];
      end
   end

   logic signed [48:0] fx13_ff, fy13_ff;
   trig_type nx13_ff, ny13_ff;
   logic     sep13_ff;
   logic [31:0] depth13_ff;

   always_ff @(posedge clock) begin
      if (en[13]) begin
         fx13_ff <= dx12_ff * sel12_ff.nx;
         fy13_ff <= dy12_ff * sel12_ff.ny;
         nx13_ff <= sel12_ff.have ? sel12_ff.nx : '0;
         ny13_ff <= sel12_ff.have ? sel12_ff.ny : '0;
         sep13_ff <= sep12_ff;
         depth13_ff <= depth_in;
      end
   end

   // ---------------- stage 14: flip and output register ----------------
   logic signed [49:0] fdot_in;
   assign fdot_in = 50'(fx13_ff) + 50'(fy13_ff);

   logic        hit14_ff;
   trig_type    nx14_ff, ny14_ff;
   logic [31:0] depth14_ff;

   always_ff @(posedge clock) begin
      if (en[14]) begin
         if (sep13_ff) begin
            hit14_ff <= 1'b0; nx14_ff <= '0; ny14_ff <= '0; depth14_ff <= '0;
         end else begin
            hit14_ff   <= 1'b1;
            nx14_ff    <= fdot_in[49] ? -nx13_ff : nx13_ff;
            ny14_ff    <= fdot_in[49] ? -ny13_ff : ny13_ff;
            depth14_ff <= depth13_ff;
         end
      end
   end

   assign rsp_tdata = {7'd0, depth14_ff, ny14_ff, nx14_ff, hit14_ff};

endmodule

// ----- hw/rtl/obbsat_chk.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obbsat_chk
// Port-level checks of the oriented-box separating-axis block.
// ---------------------------------------------------------------------------
`include "obb_pair_sat_penetration_defines.svh"

module obbsat_chk
   import obbsat_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic        hit;
   trig_type    nx, ny;
   logic [31:0] depth;

   assign hit   = rsp_tdata[HIT_LSB];
   assign nx    = rsp_tdata[NX_LSB +: 16];
   assign ny    = rsp_tdata[NY_LSB +: 16];
   assign depth = rsp_tdata[DEPTH_LSB +: 32];

   `OBB_ASSERT_ALL(a_reset_empty, clock, reset |=> !rsp_tvalid)
   `OBB_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `OBB_ASSERT_RST(a_miss_zero, clock, reset, rsp_tvalid && !hit |-> nx == 16'sd0 && ny == 16'sd0 && depth == 32'd0)
   `OBB_ASSERT_RST(a_noaxis_sat, clock, reset, rsp_tvalid && hit && nx == 16'sd0 && ny == 16'sd0 |-> depth == DEPTH_MAX)
   `OBB_ASSERT_RST(a_unit_range, clock, reset, rsp_tvalid |-> nx <= UNIT_Q14 && nx >= -UNIT_Q14 && ny <= UNIT_Q14 && ny >= -UNIT_Q14)

endmodule

bind obb_pair_sat_penetration obbsat_chk u_obbsat_chk (.*);
